FILE: hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dsde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsde_pkg
// Types, codes and sizes shared by the deque cell chain and its controller.
// ----------------------------------------------------------------------------
package dsde_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] REQ_PUSH_F = 3'd0;
  localparam logic [2:0] REQ_PUSH_B = 3'd1;
  localparam logic [2:0] REQ_POP_F  = 3'd2;
  localparam logic [2:0] REQ_POP_B  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_SORT   = 3'd5;
  localparam logic [2:0] REQ_DEDUP  = 3'd6;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               last_of_run;
    logic [1:0]         status;
    logic [5:0]         entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_SHL,
    OP_WRITE,
    OP_SORT,
    OP_CLRDEL,
    OP_MARK,
    OP_COMPACT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic               phase;
    logic [CNT_W-1:0]   cnt;
    logic [IDX_W-1:0]   bidx;
    logic signed [31:0] bval;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ,
    ST_SORT,
    ST_MARK,
    ST_COMPACT
  } state_t;

endpackage

FILE: hdl/dsde_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsde_cell
// One queue position: holds a value and a duplicate mark, trades with its
// neighbors on shifts, compare-exchange steps and compaction steps.
// ----------------------------------------------------------------------------
module dsde_cell
  import dsde_pkg::*;
(
  input  logic               clk,
  input  logic [IDX_W-1:0]   idx,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] lval,
  input  logic               ldel,
  input  logic signed [31:0] rval,
  input  logic               rdel,
  output logic signed [31:0] val,
  output logic               del
);

  logic signed [31:0] val_r, val_nxt;
  logic               del_r, del_nxt;
  logic               lower, lo_ok, up_ok, in_range;

  always_comb begin
    lower    = (idx[0] == ctl.phase);
    lo_ok    = ({1'b0, idx} + CNT_W'(1)) < ctl.cnt;
    in_range = {1'b0, idx} < ctl.cnt;
    up_ok    = (idx != '0) && in_range;
    val_nxt  = val_r;
    del_nxt  = del_r;
    unique case (ctl.op)
      OP_HOLD: begin
        val_nxt = val_r;
      end
      OP_SHR: begin
        val_nxt = lval;
      end
      OP_SHL: begin
        val_nxt = rval;
      end
      OP_WRITE: begin
        if (idx == ctl.bidx) val_nxt = ctl.bval;
      end
      OP_SORT: begin
        // lower cell keeps the min of the pair, upper the max
        if (lower && lo_ok && (val_r > rval)) val_nxt = rval;
        else if (!lower && up_ok && (lval > val_r)) val_nxt = lval;
      end
      OP_CLRDEL: begin
        del_nxt = 1'b0;
      end
      OP_MARK: begin
        if ((idx > ctl.bidx) && in_range && (val_r == ctl.bval)) del_nxt = 1'b1;
      end
      OP_COMPACT: begin
        // move kept entries ahead of marked ones, order kept
        if (lower && lo_ok && del_r && !rdel) begin
          val_nxt = rval;
          del_nxt = 1'b0;
        end else if (!lower && up_ok && ldel && !del_r) begin
          val_nxt = lval;
          del_nxt = 1'b1;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    del_r <= del_nxt;
  end

  assign val = val_r;
  assign del = del_r;

endmodule

FILE: hdl/deque_sort_dedup_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_sort_dedup_engine_top
// Bounded deque of signed words kept in a chain of cells, front at cell 0.
//
//   channel  direction  ports
//   in       input      in_valid, in_ready, in_data  (in_word_t)
//   out      output     out_valid, out_ready, out_data (out_word_t)
//
// Push and pop update the queue when accepted, then issue one result word.
// Readout issues one word per cycle while out_ready does not stall, count words (one if empty).
// Sort runs odd-even exchange passes in the chain; dedup runs one mark step per
// entry, then compaction passes; each then issues one result word.
// Reset (rst_n, synchronous) empties the queue; cell contents stay undefined.
// A stalled out_ready holds the result register and, in its result states,
// the controller.
// ----------------------------------------------------------------------------
module deque_sort_dedup_engine_top
  import dsde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  `include "assert_macros.svh"

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] pass_r, pass_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  cell_ctl_t          ctl;
  logic signed [31:0] cell_val [DEPTH];
  logic               cell_del [DEPTH];
  logic signed [31:0] sel_val;
  logic               sel_del;
  logic               acc, slot_free, full, empty, last_pass, last_read;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign last_pass = (pass_r == CNT_W'(DEPTH - 1));
  assign last_read = (ptr_r + CNT_W'(1) == cnt_r);
  assign sel_val   = cell_val[ptr_r[IDX_W-1:0]];
  assign sel_del   = cell_del[ptr_r[IDX_W-1:0]];

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic signed [31:0] lv, rv;
    logic               ld, rd;
    if (j == 0) begin : g_first
      assign lv = in_data.item_value;
      assign ld = 1'b0;
    end else begin : g_mid_l
      assign lv = cell_val[j-1];
      assign ld = cell_del[j-1];
    end
    if (j == DEPTH - 1) begin : g_last
      assign rv = '0;
      assign rd = 1'b0;
    end else begin : g_mid_r
      assign rv = cell_val[j+1];
      assign rd = cell_del[j+1];
    end
    dsde_cell u_cell (
      .clk  (clk),
      .idx  (IDX_W'(j)),
      .ctl  (ctl),
      .lval (lv),
      .ldel (ld),
      .rval (rv),
      .rdel (rd),
      .val  (cell_val[j]),
      .del  (cell_del[j])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_data.req_type)
            REQ_READ:  state_nxt = ST_READ;
            REQ_SORT:  state_nxt = ST_SORT;
            REQ_DEDUP: state_nxt = ST_MARK;
            default:   state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (slot_free && (empty || last_read)) state_nxt = ST_IDLE;
      end
      ST_SORT: begin
        if (last_pass) state_nxt = ST_EMIT;
      end
      ST_MARK: begin
        if (ptr_r >= cnt_r) state_nxt = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (last_pass) state_nxt = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.phase     = pass_r[0];
    ctl.cnt       = cnt_r;
    ctl.bidx      = ptr_r[IDX_W-1:0];
    ctl.bval      = sel_val;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    pass_nxt      = pass_r;
    kept_nxt      = kept_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          ptr_nxt    = '0;
          pass_nxt   = '0;
          kept_nxt   = '0;
          status_nxt = STS_OK;
          case (in_data.req_type)
            REQ_PUSH_F: begin
              if (full) status_nxt = STS_FULL;
              else begin
                ctl.op  = OP_SHR;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            REQ_PUSH_B: begin
              if (full) status_nxt = STS_FULL;
              else begin
                ctl.op   = OP_WRITE;
                ctl.bidx = cnt_r[IDX_W-1:0];
                ctl.bval = in_data.item_value;
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
            REQ_POP_F: begin
              if (empty) status_nxt = STS_EMPTY;
              else begin
                ctl.op  = OP_SHL;
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            REQ_POP_B: begin
              if (empty) status_nxt = STS_EMPTY;
              else cnt_nxt = cnt_r - CNT_W'(1);
            end
            REQ_DEDUP: begin
              ctl.op = OP_CLRDEL;
            end
            default: begin
              status_nxt = STS_OK;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.out_value   = '0;
          out_nxt.last_of_run = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.entry_count = 6'(cnt_r);
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.entry_count = 6'(cnt_r);
          if (empty) begin
            out_nxt.out_value   = '0;
            out_nxt.last_of_run = 1'b1;
            out_nxt.status      = STS_EMPTY;
          end else begin
            out_nxt.out_value   = sel_val;
            out_nxt.last_of_run = last_read;
            out_nxt.status      = STS_OK;
          end
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      ST_SORT: begin
        ctl.op   = OP_SORT;
        pass_nxt = pass_r + CNT_W'(1);
      end
      ST_MARK: begin
        // broadcast entry ptr, mark later copies
        if (ptr_r < cnt_r) begin
          ctl.op  = OP_MARK;
          ptr_nxt = ptr_r + CNT_W'(1);
          if (!sel_del) kept_nxt = kept_r + CNT_W'(1);
        end
      end
      ST_COMPACT: begin
        ctl.op   = OP_COMPACT;
        pass_nxt = pass_r + CNT_W'(1);
        if (last_pass) cnt_nxt = kept_r;
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    pass_r   <= pass_nxt;
    kept_r   <= kept_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_kept_bound, (state_r == ST_COMPACT) |-> (kept_r <= cnt_r), "dedup kept > count")
  `ASSERT_CLK(a_busy_no_take, (state_r != ST_IDLE) |-> !in_ready, "input taken while busy")

endmodule
